@@ rtl/mse_pkg.sv @@
package mse_pkg;

  localparam int MAX_NODES = 16;
  localparam int MAX_VSRC  = 8;
  localparam int DIM       = MAX_NODES + MAX_VSRC;
  localparam int CELLS     = DIM * DIM;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int NODE_W    = 5;
  localparam int DATA_W    = 32;
  localparam int VCNT_W    = $clog2(MAX_VSRC + 1);
  localparam int QDEPTH    = 2;
  localparam int DIV_STEPS = DATA_W + 1;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic signed [DATA_W-1:0] ONE_Q16   = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN     = 32'sh8000_0000;

  typedef enum logic [1:0] {
    FN_STAMP  = 2'd0,
    FN_READ   = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_UNUSED = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CT_RES  = 2'd0,
    CT_ISRC = 2'd1,
    CT_VSRC = 2'd2,
    CT_NONE = 2'd3
  } comp_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_NODE = 3'd1,
    ST_TOO_MANY = 3'd2,
    ST_ZERO_R   = 3'd3,
    ST_BAD_READ = 3'd4,
    ST_SAT      = 3'd5
  } status_t;

  // work class decided by the front end
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_RES   = 3'd1,
    OP_ISRC  = 3'd2,
    OP_VSRC  = 3'd3,
    OP_READ  = 3'd4,
    OP_CLEAR = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    BK_IDLE    = 4'd0,
    BK_EXEC    = 4'd1,
    BK_DIV     = 4'd2,
    BK_RMW_RD  = 4'd3,
    BK_RMW_WR  = 4'd4,
    BK_ISRC    = 4'd5,
    BK_VSRC    = 4'd6,
    BK_RD_WAIT = 4'd7,
    BK_CLR     = 4'd8,
    BK_DONE    = 4'd9
  } bk_state_t;

  typedef struct packed {
    op_t                        op;
    status_t                    status;
    logic [NODE_W-1:0]          node_a;
    logic [NODE_W-1:0]          node_b;
    logic signed [DATA_W-1:0]   value;
    logic [NODE_W-1:0]          read_row;
    logic [NODE_W-1:0]          read_col;
  } cmd_t;

  // node_count clamped to 1..MAX_NODES
  function automatic logic [NODE_W-1:0] nodes_used(input logic [NODE_W-1:0] nc);
    logic [NODE_W-1:0] r;
    r = nc;
    if (nc == '0) r = NODE_W'(1);
    else if (nc > NODE_W'(MAX_NODES)) r = NODE_W'(MAX_NODES);
    return r;
  endfunction

  // row-major matrix address
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [NODE_W-1:0] r,
                                                  input logic [NODE_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(DIM) + ADDR_W'(c);
  endfunction

endpackage

@@ rtl/mse_ifs.sv @@
interface mse_in_if;
  import mse_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               func;
  logic [1:0]               comp_type;
  logic [NODE_W-1:0]        node_a;
  logic [NODE_W-1:0]        node_b;
  logic signed [DATA_W-1:0] value;
  logic [NODE_W-1:0]        read_row;
  logic [NODE_W-1:0]        read_col;

  modport source (output valid, func, comp_type, node_a, node_b, value, read_row, read_col,
                  input ready);
  modport sink (input valid, func, comp_type, node_a, node_b, value, read_row, read_col,
                output ready);
endinterface

interface mse_out_if;
  import mse_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [NODE_W-1:0]        system_size;
  logic [2:0]               status;

  modport source (output valid, read_value, system_size, status, input ready);
  modport sink (input valid, read_value, system_size, status, output ready);
endinterface

@@ rtl/mse_ram.sv @@
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 576
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mse_front.sv @@
module mse_front
  import mse_pkg::*;
(
  mse_in_if.sink            in_if,
  input  logic [NODE_W-1:0] node_count,
  input  logic              init_busy,
  input  logic              q_ready,
  output logic              push,
  output cmd_t              cmd
);

  logic [NODE_W-1:0] n;

  assign n           = nodes_used(node_count);
  assign in_if.ready = q_ready && !init_busy;
  assign push        = in_if.valid && in_if.ready;

  // classify the beat; node and zero-resistance checks need no state
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.status   = ST_OK;
    cmd.node_a   = in_if.node_a;
    cmd.node_b   = in_if.node_b;
    cmd.value    = in_if.value;
    cmd.read_row = in_if.read_row;
    cmd.read_col = in_if.read_col;
    case (func_t'(in_if.func))
      FN_STAMP: begin
        if (comp_t'(in_if.comp_type) != CT_NONE) begin
          if (in_if.node_a > n || in_if.node_b > n) begin
            cmd.status = ST_BAD_NODE;
          end else begin
            case (comp_t'(in_if.comp_type))
              CT_RES: begin
                if (in_if.value == '0) cmd.status = ST_ZERO_R;
                else cmd.op = OP_RES;
              end
              CT_ISRC: cmd.op = OP_ISRC;
              CT_VSRC: cmd.op = OP_VSRC;
              default: cmd.op = OP_NONE;
            endcase
          end
        end
      end
      FN_READ:  cmd.op = OP_READ;
      FN_CLEAR: cmd.op = OP_CLEAR;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

@@ rtl/mse_cmd_queue.sv @@
module mse_cmd_queue
  import mse_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic push_ready,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic pop_valid
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             slot_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign push_ready = cnt_r != CNT_W'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = slot_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/mse_back.sv @@
module mse_back
  import mse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [NODE_W-1:0] node_count,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              init_busy,
  mse_out_if.source         out_if
);

  bk_state_t state_r, state_nxt;
  cmd_t      cmd_r, cmd_nxt;
  logic      init_r, init_nxt;
  logic [VCNT_W-1:0] vcount_r, vcount_nxt;
  logic signed [DATA_W-1:0] vec_r [DIM];
  logic signed [DATA_W-1:0] vec_nxt [DIM];
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [1:0]        step_r, step_nxt;
  logic              sat_r, sat_nxt;
  logic [DATA_W:0]   rem_r, rem_nxt;
  logic [DATA_W:0]   quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic signed [DATA_W-1:0] res_val_r, res_val_nxt;
  status_t           res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_val_r, out_val_nxt;
  logic [NODE_W-1:0] out_size_r, out_size_nxt;
  status_t           out_status_r, out_status_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic [NODE_W-1:0] n, size, vrow, a_idx, b_idx, rmw_r, rmw_c;
  logic              a_nz, b_nz, rmw_live, vs_live, read_bad, read_vec, div_last;
  logic [ADDR_W-1:0] rmw_addr, vs_addr, read_addr;
  logic [DATA_W:0]   trial;
  logic              qbit;
  logic              gsat;
  logic signed [DATA_W-1:0] g;
  logic [DATA_W:0]   rmw_sum, isrc_a_sum, isrc_b_sum;

  // saturating add or subtract; top bit flags saturation
  function automatic logic [DATA_W:0] sat_add(input logic signed [DATA_W-1:0] x,
                                              input logic signed [DATA_W-1:0] d,
                                              input logic sub);
    logic signed [DATA_W:0] s;
    logic signed [DATA_W-1:0] r;
    logic ovf;
    s   = sub ? ({x[DATA_W-1], x} - {d[DATA_W-1], d}) : ({x[DATA_W-1], x} + {d[DATA_W-1], d});
    ovf = s[DATA_W] != s[DATA_W-1];
    r   = ovf ? (s[DATA_W] ? Q_MIN : Q_MAX) : s[DATA_W-1:0];
    return {ovf, r};
  endfunction

  mse_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared decode of the current item
  assign n        = nodes_used(node_count);
  assign size     = n + NODE_W'(vcount_r);
  assign vrow     = size;
  assign a_nz     = cmd_r.node_a != '0;
  assign b_nz     = cmd_r.node_b != '0;
  assign a_idx    = cmd_r.node_a - 1'b1;
  assign b_idx    = cmd_r.node_b - 1'b1;
  assign read_vec = cmd_r.read_col == NODE_W'(DIM);
  assign read_bad = (cmd_r.read_row >= size) || (!read_vec && cmd_r.read_col >= size);
  assign read_addr = cell_addr(cmd_r.read_row, cmd_r.read_col);
  assign div_last = dcnt_r == '0;

  // resistor: diag a, diag b, (a,b), (b,a)
  always_comb begin
    case (step_r)
      2'd0: begin rmw_r = a_idx; rmw_c = a_idx; rmw_live = a_nz; end
      2'd1: begin rmw_r = b_idx; rmw_c = b_idx; rmw_live = b_nz; end
      2'd2: begin rmw_r = a_idx; rmw_c = b_idx; rmw_live = a_nz && b_nz; end
      default: begin rmw_r = b_idx; rmw_c = a_idx; rmw_live = a_nz && b_nz; end
    endcase
  end
  assign rmw_addr = cell_addr(rmw_r, rmw_c);

  // voltage source couplings, -1 writes after +1 writes
  always_comb begin
    case (step_r)
      2'd0: begin vs_addr = cell_addr(vrow, a_idx); vs_live = a_nz; end
      2'd1: begin vs_addr = cell_addr(a_idx, vrow); vs_live = a_nz; end
      2'd2: begin vs_addr = cell_addr(vrow, b_idx); vs_live = b_nz; end
      default: begin vs_addr = cell_addr(b_idx, vrow); vs_live = b_nz; end
    endcase
  end

  // restoring divider step for 2^32 / |R|
  assign trial = {rem_r[DATA_W-1:0], (dcnt_r == DCNT_W'(DIV_STEPS - 1))};
  assign qbit  = trial >= {1'b0, dvs_r};

  // conductance from the finished quotient, clamped to 32 bits
  always_comb begin
    if (!cmd_r.value[DATA_W-1]) begin
      gsat = quo_r > {1'b0, Q_MAX};
      g    = gsat ? Q_MAX : quo_r[DATA_W-1:0];
    end else begin
      gsat = quo_r > {1'b0, Q_MIN};
      g    = gsat ? Q_MIN : -quo_r[DATA_W-1:0];
    end
  end

  assign rmw_sum    = sat_add(ram_rdata, g, step_r[1]);
  assign isrc_a_sum = sat_add(vec_r[a_idx], cmd_r.value, 1'b1);
  assign isrc_b_sum = sat_add(vec_r[b_idx], cmd_r.value, 1'b0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (q_valid && !out_valid_r) state_nxt = BK_EXEC;
      BK_EXEC: begin
        case (cmd_r.op)
          OP_RES:   state_nxt = BK_DIV;
          OP_ISRC:  state_nxt = BK_ISRC;
          OP_VSRC:  state_nxt = (vcount_r >= VCNT_W'(MAX_VSRC)) ? BK_DONE : BK_VSRC;
          OP_READ:  state_nxt = (read_bad || read_vec) ? BK_DONE : BK_RD_WAIT;
          OP_CLEAR: state_nxt = BK_CLR;
          default:  state_nxt = BK_DONE;
        endcase
      end
      BK_DIV:    if (div_last) state_nxt = BK_RMW_RD;
      BK_RMW_RD: begin
        if (rmw_live) state_nxt = BK_RMW_WR;
        else if (step_r == 2'd3) state_nxt = BK_DONE;
      end
      BK_RMW_WR:  state_nxt = (step_r == 2'd3) ? BK_DONE : BK_RMW_RD;
      BK_ISRC:    if (step_r == 2'd1) state_nxt = BK_DONE;
      BK_VSRC:    if (step_r == 2'd3) state_nxt = BK_DONE;
      BK_RD_WAIT: state_nxt = BK_DONE;
      BK_CLR: begin
        if (clr_addr_r == ADDR_W'(CELLS - 1)) state_nxt = init_r ? BK_IDLE : BK_DONE;
      end
      BK_DONE:  state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_nxt        = cmd_r;
    init_nxt       = init_r;
    vcount_nxt     = vcount_r;
    vec_nxt        = vec_r;
    clr_addr_nxt   = clr_addr_r;
    step_nxt       = step_r;
    sat_nxt        = sat_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    dvs_nxt        = dvs_r;
    dcnt_nxt       = dcnt_r;
    res_val_nxt    = res_val_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_val_nxt    = out_val_r;
    out_size_nxt   = out_size_r;
    out_status_nxt = out_status_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = rmw_addr;
    ram_wdata      = rmw_sum[DATA_W-1:0];
    ram_raddr      = (state_r == BK_EXEC) ? read_addr : rmw_addr;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop          = 1'b1;
          cmd_nxt        = q_cmd;
          sat_nxt        = 1'b0;
          res_val_nxt    = '0;
          res_status_nxt = q_cmd.status;
        end
      end
      BK_EXEC: begin
        step_nxt = '0;
        case (cmd_r.op)
          OP_RES: begin
            dvs_nxt  = cmd_r.value[DATA_W-1] ? DATA_W'(-cmd_r.value) : DATA_W'(cmd_r.value);
            rem_nxt  = '0;
            quo_nxt  = '0;
            dcnt_nxt = DCNT_W'(DIV_STEPS - 1);
          end
          OP_VSRC: begin
            if (vcount_r >= VCNT_W'(MAX_VSRC)) res_status_nxt = ST_TOO_MANY;
          end
          OP_READ: begin
            if (read_bad) res_status_nxt = ST_BAD_READ;
            else if (read_vec) res_val_nxt = vec_r[cmd_r.read_row];
          end
          OP_CLEAR: begin
            clr_addr_nxt = '0;
            vcount_nxt   = '0;
            for (int i = 0; i < DIM; i++) vec_nxt[i] = '0;
          end
          default: ;
        endcase
      end
      BK_DIV: begin
        rem_nxt  = qbit ? (trial - {1'b0, dvs_r}) : trial;
        quo_nxt  = {quo_r[DATA_W-1:0], qbit};
        dcnt_nxt = dcnt_r - 1'b1;
      end
      BK_RMW_RD: begin
        if (step_r == 2'd0) sat_nxt = sat_r | gsat;
        if (!rmw_live && step_r != 2'd3) step_nxt = step_r + 1'b1;
      end
      BK_RMW_WR: begin
        ram_we   = 1'b1;
        sat_nxt  = sat_r | rmw_sum[DATA_W];
        step_nxt = step_r + 1'b1;
      end
      BK_ISRC: begin
        if (step_r == 2'd0) begin
          if (a_nz) begin
            vec_nxt[a_idx] = isrc_a_sum[DATA_W-1:0];
            sat_nxt        = sat_r | isrc_a_sum[DATA_W];
          end
        end else if (b_nz) begin
          vec_nxt[b_idx] = isrc_b_sum[DATA_W-1:0];
          sat_nxt        = sat_r | isrc_b_sum[DATA_W];
        end
        step_nxt = step_r + 1'b1;
      end
      BK_VSRC: begin
        ram_we    = vs_live;
        ram_waddr = vs_addr;
        ram_wdata = step_r[1] ? -ONE_Q16 : ONE_Q16;
        step_nxt  = step_r + 1'b1;
        if (step_r == 2'd3) begin
          vec_nxt[vrow] = cmd_r.value;
          vcount_nxt    = vcount_r + 1'b1;
        end
      end
      BK_RD_WAIT: res_val_nxt = ram_rdata;
      BK_CLR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(CELLS - 1)) init_nxt = 1'b0;
      end
      BK_DONE: begin
        out_valid_nxt  = 1'b1;
        out_val_nxt    = res_val_r;
        out_size_nxt   = size;
        out_status_nxt = (res_status_r == ST_OK && sat_r) ? ST_SAT : res_status_r;
      end
      default: ;
    endcase
  end

  // control state; reset starts the matrix clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLR;
      init_r      <= 1'b1;
      clr_addr_r  <= '0;
      vcount_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIM; i++) vec_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      clr_addr_r  <= clr_addr_nxt;
      vcount_r    <= vcount_nxt;
      out_valid_r <= out_valid_nxt;
      vec_r       <= vec_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    step_r       <= step_nxt;
    sat_r        <= sat_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    dvs_r        <= dvs_nxt;
    dcnt_r       <= dcnt_nxt;
    res_val_r    <= res_val_nxt;
    res_status_r <= res_status_nxt;
    out_val_r    <= out_val_nxt;
    out_size_r   <= out_size_nxt;
    out_status_r <= out_status_nxt;
  end

  assign init_busy          = init_r;
  assign out_if.valid       = out_valid_r;
  assign out_if.read_value  = out_val_r;
  assign out_if.system_size = out_size_r;
  assign out_if.status      = out_status_r;

endmodule

@@ rtl/mna_stamp_engine.sv @@
// Channel   Dir  Beat contents
// in_if     in   func, comp_type, node_a, node_b, value, read_row, read_col
// out_if    out  read_value, system_size, status (one beat per input beat)
// cfg_*     in   node_count, written when cfg_we is high
//
// Ignored, rejected and vector-read items go straight from execute to done,
// matrix reads wait for the RAM read data, current sources update two vector
// entries, voltage sources write four couplings, and resistors run the bit-serial
// reciprocal divider, then up to four read-modify-write passes on the single
// matrix RAM port pair. Clear zeroes one matrix word per cycle.
// After reset the same sweep runs with in_if.ready low.
// A two-entry queue lets input beats land while a result waits on out_if.
module mna_stamp_engine
  import mse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mse_in_if.sink            in_if,
  mse_out_if.source         out_if,
  input  logic              cfg_we,
  input  logic [NODE_W-1:0] cfg_wdata
);

  logic [NODE_W-1:0] node_count_r;
  logic              init_busy;
  logic              q_ready, q_push, q_pop, q_valid;
  cmd_t              push_cmd, pop_cmd;

  // node count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_W'(MAX_NODES);
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  mse_front u_front (
    .in_if      (in_if),
    .node_count (node_count_r),
    .init_busy  (init_busy),
    .q_ready    (q_ready),
    .push       (q_push),
    .cmd        (push_cmd)
  );

  mse_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_cmd    (pop_cmd),
    .pop_valid  (q_valid)
  );

  mse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .node_count (node_count_r),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .init_busy  (init_busy),
    .out_if     (out_if)
  );

  // a reported size always covers at least one node and at most the full system
  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.system_size >= NODE_W'(1) &&
                      out_if.system_size <= NODE_W'(DIM)))
    else $error("system_size out of range");

  // only a clean read returns data
  a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.read_value != '0) |-> (out_if.status == ST_OK))
    else $error("read_value set on a failed item");

endmodule

@@ verif/tb_ifs.sv @@
`timescale 1ns / 1ps

// Plain beat records used by the test bench
package tb_mse_pkg;
  import mse_pkg::*;

  typedef struct {
    func_t                    func;
    comp_t                    comp_type;
    logic [NODE_W-1:0]        node_a;
    logic [NODE_W-1:0]        node_b;
    logic signed [DATA_W-1:0] value;
    logic [NODE_W-1:0]        read_row;
    logic [NODE_W-1:0]        read_col;
  } stamp_beat_t;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    logic [NODE_W-1:0]        system_size;
    status_t                  status;
  } stamp_result_t;
endpackage

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import mse_pkg::*;
  import tb_mse_pkg::*;

  // Scoreboard: mirrors the MNA system and queues expected results
  class mna_scoreboard;
    logic signed [DATA_W-1:0] mat [DIM][DIM];
    logic signed [DATA_W-1:0] rhs [DIM];
    int unsigned              vcount;
    logic [NODE_W-1:0]        node_cfg;
    stamp_result_t            pending [$];
    int                       errors;

    function void clear_system();
      foreach (mat[r, c]) mat[r][c] = '0;
      foreach (rhs[r]) rhs[r] = '0;
      vcount = 0;
    endfunction

    function int unsigned active_nodes();
      if (node_cfg == 0) return 1;
      if (node_cfg > MAX_NODES) return MAX_NODES;
      return node_cfg;
    endfunction

    function logic signed [DATA_W-1:0] sat_add(longint a, longint b, inout bit sat);
      longint s;
      s = a + b;
      if (s > 64'sh7FFFFFFF) begin
        sat = 1;
        return Q_MAX;
      end
      if (s < -64'sh80000000) begin
        sat = 1;
        return Q_MIN;
      end
      return s[31:0];
    endfunction

    function void note_beat(stamp_beat_t b);
      stamp_result_t res;
      int unsigned   n, na, nb, row, size;
      bit            sat;
      longint        q, v, g;
      n = active_nodes();
      na = b.node_a;
      nb = b.node_b;
      v = b.value;
      sat = 0;
      res.read_value = '0;
      res.status = ST_OK;
      if (b.func == FN_STAMP && b.comp_type != CT_NONE) begin
        if (na > n || nb > n) begin
          res.status = ST_BAD_NODE;
        end else if (b.comp_type == CT_RES) begin
          if (v == 0) begin
            res.status = ST_ZERO_R;
          end else begin
            q = 64'sh1_0000_0000 / v;
            g = sat_add(q, 0, sat);
            if (na) mat[na-1][na-1] = sat_add(mat[na-1][na-1], g, sat);
            if (nb) mat[nb-1][nb-1] = sat_add(mat[nb-1][nb-1], g, sat);
            if (na && nb) begin
              mat[na-1][nb-1] = sat_add(mat[na-1][nb-1], -g, sat);
              mat[nb-1][na-1] = sat_add(mat[nb-1][na-1], -g, sat);
            end
          end
        end else if (b.comp_type == CT_ISRC) begin
          if (na) rhs[na-1] = sat_add(rhs[na-1], -v, sat);
          if (nb) rhs[nb-1] = sat_add(rhs[nb-1], v, sat);
        end else begin
          if (vcount >= MAX_VSRC) begin
            res.status = ST_TOO_MANY;
          end else begin
            row = n + vcount;
            if (na) begin
              mat[row][na-1] = ONE_Q16;
              mat[na-1][row] = ONE_Q16;
            end
            if (nb) begin
              mat[row][nb-1] = -ONE_Q16;
              mat[nb-1][row] = -ONE_Q16;
            end
            rhs[row] = b.value;
            vcount++;
          end
        end
        if (res.status == ST_OK && sat) res.status = ST_SAT;
      end else if (b.func == FN_READ) begin
        size = n + vcount;
        if (b.read_row >= size || b.read_row >= DIM) res.status = ST_BAD_READ;
        else if (b.read_col == DIM) res.read_value = rhs[b.read_row];
        else if (b.read_col >= size || b.read_col >= DIM) res.status = ST_BAD_READ;
        else res.read_value = mat[b.read_row][b.read_col];
      end else if (b.func == FN_CLEAR) begin
        clear_system();
      end
      res.system_size = NODE_W'(active_nodes() + vcount);
      pending.push_back(res);
    endfunction

    function void check_result(stamp_result_t got);
      stamp_result_t exp;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.read_value !== exp.read_value) begin
        $error("read_value: expected %0d, got %0d", exp.read_value, got.read_value);
        errors++;
      end
      if (got.system_size !== exp.system_size) begin
        $error("system_size: expected %0d, got %0d", exp.system_size, got.system_size);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [NODE_W-1:0] cfg_wdata;
  mse_in_if          in_if ();
  mse_out_if         out_if ();

  mna_scoreboard sb;
  int            idle_cycles;
  bit            hold_off;
  bit            timed_out;

  mna_stamp_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // gap length: mostly short, now and then long
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3);
    return $urandom_range(40, 10);
  endfunction

  // result side: random stalls, checks every beat
  always @(posedge clk) begin
    stamp_result_t got;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.read_value = out_if.read_value;
        got.system_size = out_if.system_size;
        got.status = status_t'(out_if.status);
        sb.check_result(got);
      end
      out_if.ready <= !hold_off && ($urandom_range(99) < 75);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("** mna_stamp_engine: FAILED **");
      $finish;
    end
  end

  // valid stays high into the next beat when there is no gap
  task automatic send_beat(stamp_beat_t b);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= b.func;
    in_if.comp_type <= b.comp_type;
    in_if.node_a    <= b.node_a;
    in_if.node_b    <= b.node_b;
    in_if.value     <= b.value;
    in_if.read_row  <= b.read_row;
    in_if.read_col  <= b.read_col;
    do @(posedge clk); while (!in_if.ready);
    sb.note_beat(b);
  endtask

  task automatic send(func_t f, comp_t t, int na, int nb, int v, int rr = 0, int rc = 0);
    stamp_beat_t b;
    b.func = f;
    b.comp_type = t;
    b.node_a = NODE_W'(na);
    b.node_b = NODE_W'(nb);
    b.value = v;
    b.read_row = NODE_W'(rr);
    b.read_col = NODE_W'(rc);
    send_beat(b);
  endtask

  // wait for the queue to drain, then keep idling for any tail work
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_nodes(logic [NODE_W-1:0] nc);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= nc;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.node_cfg = nc;
  endtask

  function automatic int rand_value();
    int p;
    p = $urandom_range(9);
    if (p < 4) return $urandom_range(32'h0004_0000, 32'h0000_4000);
    if (p < 6) return -$urandom_range(32'h0004_0000, 32'h0000_4000);
    if (p == 6) return $urandom_range(3) - 1;
    if (p == 7) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom;
  endfunction

  // random item, mostly valid stamps and reads for the current node count
  task automatic random_beat();
    int p, n, size;
    stamp_beat_t b;
    n = sb.active_nodes();
    size = n + sb.vcount;
    p = $urandom_range(199);
    b.node_a = NODE_W'($urandom_range(n));
    b.node_b = NODE_W'($urandom_range(n));
    if ($urandom_range(19) == 0) b.node_a = NODE_W'($urandom_range(31));
    if ($urandom_range(19) == 0) b.node_b = NODE_W'($urandom_range(31));
    b.value = rand_value();
    b.comp_type = comp_t'($urandom_range(3));
    b.read_row = NODE_W'($urandom_range(size - 1));
    b.read_col = ($urandom_range(9) == 0) ? NODE_W'(DIM) : NODE_W'($urandom_range(size - 1));
    if ($urandom_range(15) == 0) b.read_row = NODE_W'($urandom_range(31));
    if ($urandom_range(15) == 0) b.read_col = NODE_W'($urandom_range(31));
    if (p < 110) b.func = FN_STAMP;
    else if (p < 194) b.func = FN_READ;
    else if (p < 197) b.func = FN_UNUSED;
    else b.func = FN_CLEAR;
    send_beat(b);
  endtask

  initial begin
    int nsets [6] = '{16, 1, 5, 0, 31, 3};
    sb = new();
    sb.node_cfg = NODE_W'(16);
    sb.clear_system();
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    hold_off = 0;
    timed_out = 0;
    idle_cycles = 0;
    in_if.valid = 0;
    in_if.func = '0;
    in_if.comp_type = '0;
    in_if.node_a = '0;
    in_if.node_b = '0;
    in_if.value = '0;
    in_if.read_row = '0;
    in_if.read_col = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // directed: every component and the corner cases
    write_nodes(NODE_W'(4));
    send(FN_STAMP, CT_RES, 1, 2, 32'h0001_0000);
    send(FN_STAMP, CT_RES, 3, 3, 32'h0002_0000);
    send(FN_STAMP, CT_RES, 0, 4, 32'hFFFF_0000);
    send(FN_STAMP, CT_RES, 1, 0, 1);
    send(FN_STAMP, CT_RES, 2, 3, 32'h8000_0000);
    send(FN_STAMP, CT_RES, 1, 2, 0);
    send(FN_STAMP, CT_RES, 5, 1, 32'h0001_0000);
    send(FN_STAMP, CT_ISRC, 1, 2, 32'h7FFF_FFFF);
    send(FN_STAMP, CT_ISRC, 1, 2, 32'h7FFF_FFFF);
    send(FN_STAMP, CT_ISRC, 0, 31, 5);
    send(FN_STAMP, CT_VSRC, 1, 1, 32'h0005_0000);
    send(FN_STAMP, CT_VSRC, 2, 0, -32'sd7);
    send(FN_STAMP, CT_NONE, 31, 31, 32'hFFFF_FFFF);
    send(FN_UNUSED, CT_NONE, 31, 31, 32'hFFFF_FFFF, 31, 31);
    send(FN_READ, CT_RES, 0, 0, 0, 0, 0);
    send(FN_READ, CT_RES, 0, 0, 0, 4, 0);
    send(FN_READ, CT_RES, 0, 0, 0, 0, DIM);
    send(FN_READ, CT_RES, 0, 0, 0, 5, 5);
    send(FN_READ, CT_RES, 0, 0, 0, 6, 0);
    send(FN_READ, CT_RES, 0, 0, 0, 0, 31);
    repeat (7) send(FN_STAMP, CT_VSRC, 3, 4, 32'h0001_0000);
    send(FN_READ, CT_RES, 0, 0, 0, 11, DIM);
    send(FN_CLEAR, CT_RES, 0, 0, 0);

    // long receiver hold-off while items keep coming
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      repeat (12) random_beat();
    join

    // random phases over several node counts
    foreach (nsets[i]) begin
      write_nodes(NODE_W'(nsets[i]));
      repeat (250) random_beat();
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** mna_stamp_engine: PASSED **");
    else
      $display("** mna_stamp_engine: FAILED **");
    $finish;
  end
endmodule
